// ===== hw/rtl/pfe_pkg.sv =====
// pfe_pkg: shared types, constants and helper functions of the Playfair encryptor.
// Used by pfe_front, pfe_queue, pfe_back and the top level. No dependencies.

package pfe_pkg;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] LETTERS  = 5'd26;
    localparam logic [4:0] CELLS    = 5'd25;
    localparam logic [2:0] SIDE_MAX = 3'd4;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef enum logic [1:0] {
        OP_KEY,
        OP_FILL,
        OP_PAIR,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] a;
        logic [4:0] b;
    } cmd_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } rc_t;

    function automatic logic [4:0] pair_letter(input logic [4:0] ch);
        logic [4:0] v;
        begin
            v = (ch >= LETTERS) ? LETTER_X : ch;
            if (v == LETTER_J)
            begin
                v = LETTER_I;
            end
            return v;
        end
    endfunction

    function automatic rc_t pos_rc(input logic [4:0] p);
        logic [4:0] q;
        logic [2:0] r;
        logic [4:0] base;
        rc_t        res;
        begin
            q = (p >= CELLS) ? p - CELLS : p;
            if (q >= 5'd20)
            begin
                r = 3'd4;
            end
            else if (q >= 5'd15)
            begin
                r = 3'd3;
            end
            else if (q >= 5'd10)
            begin
                r = 3'd2;
            end
            else if (q >= 5'd5)
            begin
                r = 3'd1;
            end
            else
            begin
                r = 3'd0;
            end
            base    = {r, 2'b00} + {2'b00, r};
            res.row = r;
            res.col = 3'(q - base);
            return res;
        end
    endfunction

    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        begin
            return {r, 2'b00} + {2'b00, r} + {2'b00, c};
        end
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        begin
            return (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
        end
    endfunction

endpackage

// ===== hw/rtl/playfair_digraph_encryptor.sv =====
// Playfair digraph encryptor, 5x5 square with i and j sharing a cell.
// Input channel: in_valid/in_ready with kind, letter_a, letter_b, second_absent.
//   kind 0 places a key letter, 1 completes the square in alphabet order,
//   2 encrypts a pair, 3 clears the square. Only pairs produce a word.
// Output channel: out_valid/out_ready with cipher_a, cipher_b.
// A front stage normalizes each word into a command queued in a QUEUE_DEPTH-entry
// FIFO, dropping a key word whose letter lies outside the alphabet; the back end
// executes commands one at a time; a completion takes one alphabet letter per cycle.
// in_ready drops only when the queue is full. A stalled receiver holds the
// output register; the back end waits with the next result until it frees,
// while the queue keeps taking words.
// Reset: square empty, no letters used, queue empty, out_valid low.
// Depends on pfe_pkg, pfe_front, pfe_queue, pfe_back.

module playfair_digraph_encryptor
    import pfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [4:0] letter_a,
    input  logic [4:0] letter_b,
    input  logic       second_absent,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] cipher_a,
    output logic [4:0] cipher_b
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t q_head;

    pfe_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .letter_a      (letter_a),
        .letter_b      (letter_b),
        .second_absent (second_absent),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    pfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    pfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cipher_a  (cipher_a),
        .cipher_b  (cipher_b)
    );

endmodule

// ===== hw/rtl/pfe_front.sv =====
// pfe_front: takes input words, classifies them and normalizes letters into commands.
// Depends on pfe_pkg; feeds pfe_queue.

module pfe_front
    import pfe_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [4:0] letter_a,
    input  logic [4:0] letter_b,
    input  logic       second_absent,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic       keep;
    logic [4:0] pa;
    logic [4:0] pb;

    assign in_ready = !q_full;

    always_comb
    begin
        keep     = 1'b1;
        q_cmd.op = OP_KEY;
        q_cmd.a  = letter_a;
        q_cmd.b  = LETTER_X;
        pa       = pair_letter(letter_a);
        pb       = second_absent ? LETTER_X : pair_letter(letter_b);
        case (kind)
            KIND_KEY:
            begin
                q_cmd.op = OP_KEY;
                keep     = (letter_a < LETTERS);
                q_cmd.a  = (letter_a == LETTER_J) ? LETTER_I : letter_a;
            end
            KIND_FILL:
            begin
                q_cmd.op = OP_FILL;
            end
            KIND_PAIR:
            begin
                q_cmd.op = OP_PAIR;
                q_cmd.a  = pa;
                q_cmd.b  = (pa == pb) ? LETTER_X : pb;
            end
            KIND_CLEAR:
            begin
                q_cmd.op = OP_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = in_valid && in_ready && keep;

endmodule

// ===== hw/rtl/pfe_queue.sv =====
// pfe_queue: small command FIFO between the front and back parts.
// Depends on pfe_pkg for the command type.

module pfe_queue
    import pfe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/pfe_back.sv =====
// pfe_back: executes commands; holds the square and position memories, the
// used-letter flags and fill count, and the output register. Depends on pfe_pkg.

module pfe_back
    import pfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] cipher_a,
    output logic [4:0] cipher_b
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_CELL,
        S_EMIT
    } state_t;

    logic [4:0] cell_mem [0:24];
    logic [4:0] pos_mem  [0:25];

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [25:0] used_reg, used_next;
    logic [4:0]  fill_reg, fill_next;
    logic [4:0]  ch_reg, ch_next;
    logic        out_valid_reg, out_valid_next;
    logic [4:0]  cipher_a_reg, cipher_a_next;
    logic [4:0]  cipher_b_reg, cipher_b_next;

    logic [4:0]  pa_reg;
    logic [4:0]  pb_reg;
    logic [4:0]  ca_reg;
    logic [4:0]  cb_reg;

    logic        place_en;
    logic [4:0]  place_ch;
    logic [4:0]  fill_ch;
    rc_t         rc1;
    rc_t         rc2;
    logic [4:0]  o1;
    logic [4:0]  o2;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign fill_ch  = (ch_reg == LETTER_J) ? LETTER_I : ch_reg;

    always_comb
    begin
        rc1 = pos_rc(pa_reg);
        rc2 = pos_rc(pb_reg);
        if (rc1.row == rc2.row)
        begin
            o1 = cell_index(rc1.row, wrap_inc(rc1.col));
            o2 = cell_index(rc2.row, wrap_inc(rc2.col));
        end
        else if (rc1.col == rc2.col)
        begin
            o1 = cell_index(wrap_inc(rc1.row), rc1.col);
            o2 = cell_index(wrap_inc(rc2.row), rc2.col);
        end
        else
        begin
            o1 = cell_index(rc1.row, rc2.col);
            o2 = cell_index(rc2.row, rc1.col);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        used_next      = used_reg;
        fill_next      = fill_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cipher_a_next  = cipher_a_reg;
        cipher_b_next  = cipher_b_reg;
        q_pop          = 1'b0;
        place_en       = 1'b0;
        place_ch       = cmd_reg.a;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_KEY:
                    begin
                        place_ch   = cmd_reg.a;
                        place_en   = (fill_reg < CELLS) && !used_reg[cmd_reg.a];
                        state_next = S_IDLE;
                    end
                    OP_FILL:
                    begin
                        ch_next    = '0;
                        state_next = S_FILL;
                    end
                    OP_PAIR:
                    begin
                        state_next = S_CELL;
                    end
                    OP_CLEAR:
                    begin
                        used_next  = '0;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FILL:
            begin
                if ((fill_reg >= CELLS) || (ch_reg >= LETTERS))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    place_ch = fill_ch;
                    place_en = !used_reg[fill_ch];
                    ch_next  = ch_reg + 5'd1;
                end
            end
            S_CELL:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cipher_a_next  = ca_reg;
                    cipher_b_next  = cb_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (place_en)
        begin
            used_next[place_ch] = 1'b1;
            if (place_ch == LETTER_I)
            begin
                used_next[LETTER_J] = 1'b1;
            end
            fill_next = fill_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            cell_mem[fill_reg] <= place_ch;
            pos_mem[place_ch]  <= fill_reg;
        end
        pa_reg <= pos_mem[cmd_reg.a];
        pb_reg <= pos_mem[cmd_reg.b];
        ca_reg <= cell_mem[o1];
        cb_reg <= cell_mem[o2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            used_reg      <= '0;
            fill_reg      <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            cipher_a_reg  <= '0;
            cipher_b_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            cipher_a_reg  <= cipher_a_next;
            cipher_b_reg  <= cipher_b_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cipher_a  = cipher_a_reg;
    assign cipher_b  = cipher_b_reg;

endmodule

// ===== tb/sv/tb_playfair_digraph_encryptor.sv =====
// Testbench for playfair_digraph_encryptor: directed table, then random key/fill/pair/clear words.
// Expected cipher words: typed directed values, else an in-bench square model. Depends on pfe_pkg.
`timescale 1ns / 100ps

module tb_playfair_digraph_encryptor;
    import pfe_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int WORD_TARGET  = 800;
    localparam int CALM_FROM    = 1200;
    localparam int CALM_TO      = 2200;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_ROWS = 25;
    localparam int SIDE_LEN     = 5;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] b;
    } cipher_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] la;
        logic [4:0] lb;
        logic       absent;
        logic       typed;
        logic [4:0] want_a;
        logic [4:0] want_b;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] kind = KIND_KEY;
    logic [4:0] letter_a = 5'd0;
    logic [4:0] letter_b = 5'd0;
    logic       second_absent = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [4:0] cipher_a;
    logic [4:0] cipher_b;

    logic       hold_off = 1'b0;
    int         cyc = 0;
    int         n_errors = 0;
    int         words_done = 0;

    // square model
    logic [4:0]  sq_letter [CELLS];
    logic [4:0]  sq_cell_of [LETTERS];
    logic [25:0] sq_used;
    int          sq_fill;

    cipher_t     cipher_q [$];
    stim_row_t   directed_rows [DIRECTED_ROWS];

    playfair_digraph_encryptor u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .letter_a      (letter_a),
        .letter_b      (letter_b),
        .second_absent (second_absent),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cipher_a      (cipher_a),
        .cipher_b      (cipher_b)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic bit calm_phase();
        return (cyc >= CALM_FROM) && (cyc < CALM_TO);
    endfunction

    function automatic logic [4:0] rand_letter();
        if ($urandom_range(0, 99) < 12)
        begin
            return 5'($urandom_range(26, 31));
        end
        return 5'($urandom_range(0, 25));
    endfunction

    function automatic void square_clear();
        for (int i = 0; i < CELLS; i++)
        begin
            sq_letter[i] = 5'd0;
        end
        for (int i = 0; i < LETTERS; i++)
        begin
            sq_cell_of[i] = 5'd0;
        end
        sq_used = '0;
        sq_fill = 0;
    endfunction

    function automatic bit square_place(input logic [4:0] letter);
        logic [4:0] ch;
        ch = (letter == LETTER_J) ? LETTER_I : letter;
        if (sq_fill >= CELLS || sq_used[ch])
        begin
            return 1'b0;
        end
        sq_letter[sq_fill] = ch;
        sq_cell_of[ch] = 5'(sq_fill);
        sq_used[ch] = 1'b1;
        if (ch == LETTER_I)
        begin
            sq_cell_of[LETTER_J] = 5'(sq_fill);
            sq_used[LETTER_J] = 1'b1;
        end
        sq_fill++;
        return 1'b1;
    endfunction

    function automatic bit square_complete();
        bit took;
        took = 1'b0;
        for (int ch = 0; ch < LETTERS && sq_fill < CELLS; ch++)
        begin
            if (square_place(5'(ch)))
            begin
                took = 1'b1;
            end
        end
        return took;
    endfunction

    function automatic logic [4:0] plain_letter(input logic [4:0] v);
        if (v >= LETTERS)
        begin
            return LETTER_X;
        end
        return (v == LETTER_J) ? LETTER_I : v;
    endfunction

    function automatic cipher_t playfair_encrypt(input logic [4:0] la, input logic [4:0] lb,
                                                 input logic absent);
        logic [4:0] a;
        logic [4:0] b;
        int         pa;
        int         pb;
        int         r1;
        int         c1;
        int         r2;
        int         c2;
        int         o1;
        int         o2;
        cipher_t    res;
        a = plain_letter(la);
        b = absent ? LETTER_X : plain_letter(lb);
        if (a == b)
        begin
            b = LETTER_X;
        end
        pa = int'(sq_cell_of[a]) % CELLS;
        pb = int'(sq_cell_of[b]) % CELLS;
        r1 = pa / SIDE_LEN;
        c1 = pa % SIDE_LEN;
        r2 = pb / SIDE_LEN;
        c2 = pb % SIDE_LEN;
        if (r1 == r2)
        begin
            o1 = r1 * SIDE_LEN + (c1 + 1) % SIDE_LEN;
            o2 = r2 * SIDE_LEN + (c2 + 1) % SIDE_LEN;
        end
        else if (c1 == c2)
        begin
            o1 = ((r1 + 1) % SIDE_LEN) * SIDE_LEN + c1;
            o2 = ((r2 + 1) % SIDE_LEN) * SIDE_LEN + c2;
        end
        else
        begin
            o1 = r1 * SIDE_LEN + c2;
            o2 = r2 * SIDE_LEN + c1;
        end
        res.a = sq_letter[o1];
        res.b = sq_letter[o2];
        return res;
    endfunction

    // called at a rising edge; returns at the edge that accepted the word
    task automatic send_word(input logic [1:0] k, input logic [4:0] la, input logic [4:0] lb,
                             input logic absent, input logic typed,
                             input logic [4:0] want_a, input logic [4:0] want_b);
        cipher_t want;
        while (!calm_phase() && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        letter_a      <= la;
        letter_b      <= lb;
        second_absent <= absent;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        case (k)
            KIND_KEY:
            begin
                if (la < LETTERS)
                begin
                    void'(square_place(la));
                end
            end
            KIND_FILL:
            begin
                void'(square_complete());
            end
            KIND_CLEAR:
            begin
                square_clear();
            end
            default:
            begin
                want.a = want_a;
                want.b = want_b;
                cipher_q.push_back(typed ? want : playfair_encrypt(la, lb, absent));
            end
        endcase
        words_done++;
    endtask

    task automatic send_plain(input logic [1:0] k, input logic [4:0] la, input logic [4:0] lb,
                              input logic absent);
        send_word(k, la, lb, absent, 1'b0, 5'd0, 5'd0);
    endtask

    task automatic run_random_words();
        int         perm [LETTERS];
        int         mode;
        int         n;
        int         j;
        int         t;
        logic [4:0] la;
        logic [4:0] lb;
        while (words_done < WORD_TARGET)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                send_plain(KIND_CLEAR, 5'($urandom), 5'($urandom), 1'($urandom));
            end
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                // whole alphabet as key letters, j and i collide
                for (int i = 0; i < LETTERS; i++)
                begin
                    perm[i] = i;
                end
                for (int i = LETTERS - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    t = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
                for (int i = 0; i < LETTERS; i++)
                begin
                    send_plain(KIND_KEY, 5'(perm[i]), 5'($urandom), 1'($urandom));
                end
            end
            else if (mode == 1)
            begin
                // broken sequence: keys without completion
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    send_plain(KIND_KEY, rand_letter(), 5'($urandom), 1'($urandom));
                end
            end
            else
            begin
                n = $urandom_range(0, 20);
                repeat (n)
                begin
                    send_plain(KIND_KEY, rand_letter(), 5'($urandom), 1'($urandom));
                end
                send_plain(KIND_FILL, 5'($urandom), 5'($urandom), 1'($urandom));
            end
            if (sq_fill == CELLS)
            begin
                n = $urandom_range(3, 40);
                repeat (n)
                begin
                    if ($urandom_range(0, 99) < 6)
                    begin
                        send_plain($urandom_range(0, 1) ? KIND_KEY : KIND_FILL,
                                   rand_letter(), 5'($urandom), 1'($urandom));
                    end
                    else
                    begin
                        la = rand_letter();
                        lb = ($urandom_range(0, 9) == 0) ? la : rand_letter();
                        send_plain(KIND_PAIR, la, lb, $urandom_range(0, 9) == 0);
                    end
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        cipher_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_q.size() == 0)
            begin
                $error("cipher word with none expected: cipher_a %0d cipher_b %0d",
                       cipher_a, cipher_b);
                n_errors++;
            end
            else
            begin
                want = cipher_q.pop_front();
                if (cipher_a !== want.a)
                begin
                    $error("cipher_a expected %0d actual %0d", want.a, cipher_a);
                    n_errors++;
                end
                if (cipher_b !== want.b)
                begin
                    $error("cipher_b expected %0d actual %0d", want.b, cipher_b);
                    n_errors++;
                end
            end
        end
        out_ready <= !hold_off && (calm_phase() || $urandom_range(0, 99) >= 25);
    end

    // long receiver stall while words keep coming
    initial
    begin
        wait (words_done >= HOLD_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        square_clear();
        directed_rows = '{
            '{KIND_FILL,  5'd31, 5'd31, 1'b1, 1'b0, 5'd0,  5'd0},   // alphabet square
            '{KIND_PAIR,  5'd0,  5'd1,  1'b0, 1'b1, 5'd1,  5'd2},   // same row
            '{KIND_PAIR,  5'd0,  5'd5,  1'b0, 1'b1, 5'd5,  5'd11},  // same column
            '{KIND_PAIR,  5'd0,  5'd25, 1'b0, 1'b1, 5'd4,  5'd21},  // rectangle
            '{KIND_PAIR,  5'd25, 5'd24, 1'b0, 1'b1, 5'd21, 5'd25},  // row wrap
            '{KIND_PAIR,  5'd9,  5'd8,  1'b0, 1'b1, 5'd7,  5'd24},  // j as i, equal
            '{KIND_PAIR,  5'd0,  5'd31, 1'b1, 1'b1, 5'd2,  5'd21},  // missing second
            '{KIND_PAIR,  5'd23, 5'd23, 1'b0, 1'b1, 5'd24, 5'd24},  // xx
            '{KIND_PAIR,  5'd31, 5'd31, 1'b0, 1'b1, 5'd24, 5'd24},  // out of range
            '{KIND_PAIR,  5'd30, 5'd0,  1'b0, 1'b1, 5'd21, 5'd2},
            '{KIND_PAIR,  5'd25, 5'd26, 1'b0, 1'b1, 5'd21, 5'd24},
            '{KIND_KEY,   5'd16, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0},   // square full
            '{KIND_FILL,  5'd0,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_CLEAR, 5'd31, 5'd31, 1'b1, 1'b0, 5'd0,  5'd0},
            '{KIND_KEY,   5'd9,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},   // j takes i's cell
            '{KIND_KEY,   5'd31, 5'd31, 1'b1, 1'b0, 5'd0,  5'd0},
            '{KIND_KEY,   5'd15, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_KEY,   5'd8,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_KEY,   5'd15, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_KEY,   5'd25, 5'd0,  1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_FILL,  5'd0,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_PAIR,  5'd7,  5'd4,  1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_PAIR,  5'd16, 5'd0,  1'b1, 1'b0, 5'd0,  5'd0},
            '{KIND_PAIR,  5'd9,  5'd31, 1'b0, 1'b0, 5'd0,  5'd0},
            '{KIND_PAIR,  5'd0,  5'd0,  1'b0, 1'b0, 5'd0,  5'd0}
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_word(directed_rows[i].kind, directed_rows[i].la, directed_rows[i].lb,
                      directed_rows[i].absent, directed_rows[i].typed,
                      directed_rows[i].want_a, directed_rows[i].want_b);
        end
        run_random_words();
        in_valid <= 1'b0;
        while (cipher_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && cipher_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== playfair_digraph_encryptor.f =====
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_front.sv
hw/rtl/pfe_queue.sv
hw/rtl/pfe_back.sv
hw/rtl/playfair_digraph_encryptor.sv
tb/sv/tb_playfair_digraph_encryptor.sv
